[sv/bounded_dfs_path_search_assert.svh]
// assertion macros for the bounded depth-first path search block
// uses the clk and arst_n names of the module that includes it
`ifndef BOUNDED_DFS_PATH_SEARCH_ASSERT_SVH
`define BOUNDED_DFS_PATH_SEARCH_ASSERT_SVH
`ifndef SYNTH
`define BDPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BDPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDPS_ASSERT(lbl, prop, msg)
`define BDPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/bdps_pkg.sv]
// shared types and constants of the bounded depth-first path search block
// no dependencies
`default_nettype none
package bdps_pkg;
	localparam int SLOT_W = 7;
	localparam int LVL_W = 5;
	localparam int LIM_W = 6;
	localparam int ID_W = 8;
	localparam int NBR_W = 8;
	localparam int NBR_SLOTS = 4;
	localparam int ORDER_LEN = 32;
	localparam int ORDER_AW = 5;
	localparam logic [NBR_W-1:0] LIST_END = 8'hFF;

	typedef struct packed {
		logic [63:0] mask_high;
		logic [63:0] mask_low;
		logic [NBR_SLOTS-1:0][NBR_W-1:0] nbr;
	} slot_entry_t;

	typedef struct packed {
		logic wr;
		logic [SLOT_W-1:0] addr;
		slot_entry_t data;
	} mem_req_t;
endpackage
`default_nettype wire

[sv/bdps_slot_mem.sv]
// slot table memory: id masks and neighbour lists, one port, registered read
// depends on bdps_pkg
`default_nettype none
module bdps_slot_mem #(
	parameter int NUM_SLOTS = 128
) (
	input  wire logic                clk,
	input  wire bdps_pkg::mem_req_t  req,
	output bdps_pkg::slot_entry_t    rd_data
);
	import bdps_pkg::*;

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	slot_entry_t mem_q [NUM_SLOTS];
	logic [AW-1:0] a;

	assign a = req.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[a] <= req.data;
		end
		rd_data <= mem_q[a];
	end
endmodule
`default_nettype wire

[sv/bounded_dfs_path_search.sv]
// Bounded depth-first path search. A write beat (req_type 0) loads one slot.
// A search beat walks the slot graph depth first from the start slot with an explicit
// frame stack; the slot table has a single port with a registered read. Each slot the
// walk tries to enter takes an enter step, each neighbour examined takes a step, and
// each frame left takes a pop step, then a re-read of the parent entry (the start frame
// needs no re-read). How many slots are entered and neighbours examined depends on
// the data.
// The best path then leaves one beat per cycle per position (one beat if not found),
// each held while out_stall is high.
// No input beat is taken while a search or its result beats are in progress; the next
// input beat can be taken in the cycle after the last result beat is accepted.
// depends on bdps_pkg, bdps_slot_mem, bounded_dfs_path_search_assert.svh
`default_nettype none
`include "bounded_dfs_path_search_assert.svh"
module bounded_dfs_path_search #(
	parameter int NUM_SLOTS = 128,
	parameter int MAX_DEPTH = 32,
	parameter int MAX_NEIGHBOURS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [6:0]  slot,
	input  wire logic [63:0] mask_low,
	input  wire logic [63:0] mask_high,
	input  wire logic [7:0]  neighbour0,
	input  wire logic [7:0]  neighbour1,
	input  wire logic [7:0]  neighbour2,
	input  wire logic [7:0]  neighbour3,
	input  wire logic        visited_in,
	input  wire logic [7:0]  wanted_id,
	input  wire logic [4:0]  start_depth,
	input  wire logic [5:0]  initial_limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       path_slot,
	output logic [4:0]       path_pos,
	output logic             last,
	output logic             found,
	output logic [5:0]       return_depth,
	output logic [5:0]       final_limit,
	output logic [6:0]       target_slot
);
	import bdps_pkg::*;

	localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SP_W = $clog2(MAX_DEPTH + 1);
	localparam int SP_AW = $clog2(MAX_DEPTH);
	localparam int NX_W = $clog2(MAX_NEIGHBOURS + 1);
	localparam logic [7:0] NSLOTS8 = 8'(NUM_SLOTS);
	localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(MAX_DEPTH);
	localparam logic [NX_W-1:0] NX_MAX = NX_W'(MAX_NEIGHBOURS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ENTER = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_REFILL = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] st_q;
	logic [LIM_W-1:0] limit_q, best_len_q, last_ret_q;
	logic [ID_W-1:0] wanted_q;
	logic any_hit_q;
	logic [SLOT_W-1:0] hit_slot_q, ent_slot_q;
	logic [LVL_W-1:0] ent_lvl_q;
	logic [SP_W-1:0] sp_q;
	logic [ORDER_AW-1:0] k_q;
	logic [NBR_SLOTS-1:0][NBR_W-1:0] top_nbr_q;
	logic [NUM_SLOTS-1:0] visited_q;
	logic [SLOT_W-1:0] order_q [ORDER_LEN];
	logic [SLOT_W-1:0] best_q [ORDER_LEN];
	logic [SLOT_W-1:0] stk_node_q [MAX_DEPTH];
	logic [LVL_W-1:0] stk_lvl_q [MAX_DEPTH];
	logic [NX_W-1:0] stk_next_q [MAX_DEPTH];

	mem_req_t req;
	slot_entry_t rd;
	logic in_acc, out_acc, slot_ok, hit, cut, deep, more, nb_ok, nb_go;
	logic [127:0] mask128;
	logic [LIM_W-1:0] lvl1;
	logic [SP_W-1:0] sp_m1, sp_m2;
	logic [SP_AW-1:0] top_i, prev_i;
	logic [SLOT_W-1:0] t_node;
	logic [LVL_W-1:0] t_lvl;
	logic [NX_W-1:0] t_next;
	logic [3:0] nx4;
	logic [NBR_W-1:0] nb;

	bdps_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
		.clk(clk),
		.req(req),
		.rd_data(rd)
	);

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = (st_q == ST_OUT);
	assign out_acc = out_valid && !out_stall;
	assign slot_ok = {1'b0, slot} < NSLOTS8;

	assign mask128 = {rd.mask_high, rd.mask_low};
	assign hit = mask128[wanted_q[6:0]] && !wanted_q[7];
	assign lvl1 = {1'b0, ent_lvl_q} + LIM_W'(1);
	assign cut = lvl1 > limit_q;
	assign deep = lvl1 >= DEPTH_LIM;

	assign sp_m1 = sp_q - SP_W'(1);
	assign sp_m2 = sp_q - SP_W'(2);
	assign top_i = sp_m1[SP_AW-1:0];
	assign prev_i = sp_m2[SP_AW-1:0];
	assign t_node = stk_node_q[top_i];
	assign t_lvl = stk_lvl_q[top_i];
	assign t_next = stk_next_q[top_i];
	assign nx4 = 4'(t_next);
	assign nb = (nx4 < 4'd4) ? top_nbr_q[nx4[1:0]] : LIST_END;
	assign more = t_next < NX_MAX;
	assign nb_ok = (nb != LIST_END) && (nb < NSLOTS8);
	assign nb_go = nb_ok && !visited_q[nb[SLOT_AW-1:0]];

	always_comb begin
		req.wr = 1'b0;
		req.addr = '0;
		req.data.mask_low = mask_low;
		req.data.mask_high = mask_high;
		req.data.nbr = {neighbour3, neighbour2, neighbour1, neighbour0};
		case (st_q)
			ST_IDLE: begin
				req.addr = slot;
				req.wr = in_acc && !req_type && slot_ok;
			end
			ST_STEP: begin
				req.addr = more ? nb[SLOT_W-1:0] : stk_node_q[prev_i];
			end
			default: begin
				req.addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			limit_q <= '0;
			best_len_q <= '0;
			last_ret_q <= '0;
			wanted_q <= '0;
			any_hit_q <= 1'b0;
			hit_slot_q <= '0;
			ent_slot_q <= '0;
			ent_lvl_q <= '0;
			sp_q <= '0;
			k_q <= '0;
			top_nbr_q <= '0;
			visited_q <= '0;
			for (int j = 0; j < ORDER_LEN; j++) begin
				order_q[j] <= '0;
			end
			for (int j = 0; j < MAX_DEPTH; j++) begin
				stk_node_q[j] <= '0;
				stk_lvl_q[j] <= '0;
				stk_next_q[j] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!req_type) begin
							if (slot_ok) begin
								visited_q[slot[SLOT_AW-1:0]] <= visited_in;
							end
						end else begin
							limit_q <= initial_limit;
							wanted_q <= wanted_id;
							any_hit_q <= 1'b0;
							best_len_q <= '0;
							hit_slot_q <= '0;
							last_ret_q <= '0;
							sp_q <= '0;
							k_q <= '0;
							ent_slot_q <= slot;
							ent_lvl_q <= start_depth;
							st_q <= slot_ok ? ST_ENTER : ST_OUT;
						end
					end
				end
				ST_ENTER: begin
					st_q <= (sp_q == '0) ? ST_OUT : ST_STEP;
					if (cut) begin
						last_ret_q <= '0;
					end else begin
						order_q[ent_lvl_q] <= ent_slot_q;
						if (hit) begin
							visited_q[ent_slot_q[SLOT_AW-1:0]] <= 1'b1;
							limit_q <= lvl1;
							best_len_q <= lvl1;
							hit_slot_q <= ent_slot_q;
							any_hit_q <= 1'b1;
							last_ret_q <= lvl1;
						end else if (deep) begin
							visited_q[ent_slot_q[SLOT_AW-1:0]] <= 1'b0;
							last_ret_q <= '0;
						end else begin
							visited_q[ent_slot_q[SLOT_AW-1:0]] <= 1'b1;
							stk_node_q[sp_q[SP_AW-1:0]] <= ent_slot_q;
							stk_lvl_q[sp_q[SP_AW-1:0]] <= ent_lvl_q;
							stk_next_q[sp_q[SP_AW-1:0]] <= '0;
							sp_q <= sp_q + SP_W'(1);
							top_nbr_q <= rd.nbr;
							st_q <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					if (more) begin
						stk_next_q[top_i] <= (nb == LIST_END) ? NX_MAX : t_next + NX_W'(1);
						if (nb_go) begin
							ent_slot_q <= nb[SLOT_W-1:0];
							ent_lvl_q <= t_lvl + LVL_W'(1);
							st_q <= ST_ENTER;
						end
					end else begin
						visited_q[t_node[SLOT_AW-1:0]] <= 1'b0;
						last_ret_q <= limit_q;
						sp_q <= sp_m1;
						st_q <= (sp_q == SP_W'(1)) ? ST_OUT : ST_REFILL;
					end
				end
				ST_REFILL: begin
					top_nbr_q <= rd.nbr;
					st_q <= ST_STEP;
				end
				ST_OUT: begin
					if (out_acc) begin
						if (last) begin
							st_q <= ST_IDLE;
							k_q <= '0;
						end else begin
							k_q <= k_q + ORDER_AW'(1);
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// snapshot of the order buffer on a hit, including the hit slot itself
	always_ff @(posedge clk) begin
		if (st_q == ST_ENTER && !cut && hit) begin
			for (int j = 0; j < ORDER_LEN; j++) begin
				best_q[j] <= (ORDER_AW'(j) == ent_lvl_q) ? ent_slot_q : order_q[j];
			end
		end
	end

	assign found = any_hit_q;
	assign path_slot = any_hit_q ? best_q[k_q] : '0;
	assign path_pos = any_hit_q ? k_q : '0;
	assign last = !any_hit_q || ((LIM_W'(k_q) + LIM_W'(1)) == best_len_q);
	assign return_depth = last_ret_q;
	assign final_limit = limit_q;
	assign target_slot = hit_slot_q;

	`BDPS_ASSERT(a_sp_bound, (sp_q < SP_W'(MAX_DEPTH)), "frame stack overflow")
	`BDPS_ASSERT(a_step_has_frame, (st_q == ST_STEP) |-> (sp_q != '0), "step with empty stack")
	`BDPS_ASSERT(a_refill_has_frame, (st_q == ST_REFILL) |-> (sp_q != '0),
		"refill with empty stack")
	`BDPS_ASSERT(a_last_to_idle, (out_acc && last) |=> (st_q == ST_IDLE), "no return to idle")
	`BDPS_ASSERT(a_pos_in_path, (out_valid && found) |-> (LIM_W'(path_pos) < final_limit),
		"position beyond best path")
endmodule
`default_nettype wire

[tb/bounded_dfs_path_search_tb.sv]
// self-checking testbench for bounded_dfs_path_search: directed table, then random writes and searches
// predicts every result beat with its own copy of the slot table; depends on bdps_pkg and the rtl only
`default_nettype none
module bounded_dfs_path_search_tb;
	import bdps_pkg::*;

	localparam bit REQ_WRITE = 1'b0;
	localparam bit REQ_SEARCH = 1'b1;
	localparam int N_SLOTS = 128;
	localparam int DEPTH_CAP = 32;
	localparam int N_RANDOM = 185;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		bit [6:0] path_slot;
		bit [4:0] path_pos;
		bit last;
		bit found;
		bit [5:0] return_depth;
		bit [5:0] final_limit;
		bit [6:0] target_slot;
	} path_beat_t;

	typedef struct {
		bit req;
		bit [6:0] slot;
		bit [63:0] ml, mh;
		bit [7:0] n0, n1, n2, n3;
		bit vis;
		bit [7:0] id;
		bit [4:0] sd;
		bit [5:0] lim;
		bit typed;
		bit e_found;
		bit [5:0] e_ret, e_lim;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic req_type = 0;
	logic [6:0] slot = 0;
	logic [63:0] mask_low = 0, mask_high = 0;
	logic [7:0] neighbour0 = 0, neighbour1 = 0, neighbour2 = 0, neighbour3 = 0;
	logic visited_in = 0;
	logic [7:0] wanted_id = 0;
	logic [4:0] start_depth = 0;
	logic [5:0] initial_limit = 0;
	logic out_valid;
	logic out_stall = 1;
	logic [6:0] path_slot;
	logic [4:0] path_pos;
	logic last, found;
	logic [5:0] return_depth, final_limit;
	logic [6:0] target_slot;

	bounded_dfs_path_search u_dut (.*);

	always #1 clk = ~clk;

	// predictor state
	bit [63:0] pm_low [N_SLOTS];
	bit [63:0] pm_high [N_SLOTS];
	bit [7:0] pm_nbr [N_SLOTS][4];
	bit pm_vis [N_SLOTS];
	bit [6:0] pm_order [DEPTH_CAP];
	bit [6:0] best [DEPTH_CAP];
	int limit_now, best_len, hit_at, ret_val;
	bit hit_any;
	int fr_node [DEPTH_CAP+1];
	int fr_lvl [DEPTH_CAP+1];
	int fr_next [DEPTH_CAP+1];
	int sp;

	path_beat_t expected_beats[$];
	bit written [N_SLOTS];
	row_t rows[$];
	int errors = 0;
	int cycles = 0;
	int beats_taken = 0;

	function automatic bit has_id(int s, int id);
		if (id < 64) return pm_low[s][id];
		if (id < 128) return pm_high[s][id-64];
		return 0;
	endfunction

	function automatic void enter_slot(int s, int lvl, int id);
		if (lvl + 1 > limit_now) begin
			ret_val = 0;
			return;
		end
		pm_vis[s] = 1;
		pm_order[lvl % DEPTH_CAP] = 7'(s);
		if (has_id(s, id)) begin
			best = pm_order;
			limit_now = lvl + 1;
			best_len = lvl + 1;
			hit_at = s;
			hit_any = 1;
			ret_val = lvl + 1;
			return;
		end
		if (lvl + 1 >= DEPTH_CAP || sp >= DEPTH_CAP + 1) begin
			pm_vis[s] = 0;
			ret_val = 0;
			return;
		end
		fr_node[sp] = s;
		fr_lvl[sp] = lvl;
		fr_next[sp] = 0;
		sp++;
	endfunction

	function automatic void predict_search(int s, int lvl, int id, int lim);
		int nb;
		path_beat_t b;
		limit_now = lim;
		hit_any = 0;
		best_len = 0;
		hit_at = 0;
		ret_val = 0;
		sp = 0;
		enter_slot(s, lvl, id);
		while (sp > 0) begin
			if (fr_next[sp-1] < NBR_SLOTS) begin
				nb = pm_nbr[fr_node[sp-1]][fr_next[sp-1]];
				fr_next[sp-1]++;
				if (nb == LIST_END) fr_next[sp-1] = NBR_SLOTS;
				else if (nb < N_SLOTS && !pm_vis[nb]) enter_slot(nb, fr_lvl[sp-1] + 1, id);
			end else begin
				pm_vis[fr_node[sp-1]] = 0;
				ret_val = limit_now;
				sp--;
			end
		end
		if (!hit_any || best_len == 0 || best_len > DEPTH_CAP) begin
			b = '{0, 0, 1, 0, ret_val[5:0], limit_now[5:0], 0};
			expected_beats.push_back(b);
			return;
		end
		for (int k = 0; k < best_len; k++) begin
			b = '{best[k], k[4:0], k + 1 == best_len, 1, ret_val[5:0], limit_now[5:0],
				hit_at[6:0]};
			expected_beats.push_back(b);
		end
	endfunction

	function automatic row_t wr(bit [6:0] s, bit [63:0] ml, bit [63:0] mh, bit [7:0] a,
			bit [7:0] b, bit [7:0] c, bit [7:0] d, bit v);
		row_t r;
		r = '{default: 0};
		r.req = REQ_WRITE;
		r.slot = s; r.ml = ml; r.mh = mh;
		r.n0 = a; r.n1 = b; r.n2 = c; r.n3 = d; r.vis = v;
		return r;
	endfunction

	function automatic row_t sr(bit [6:0] s, bit [7:0] id, bit [4:0] sd, bit [5:0] lim,
			bit typed, bit ef, bit [5:0] er, bit [5:0] el);
		row_t r;
		r = '{default: 0};
		r.req = REQ_SEARCH;
		r.slot = s; r.id = id; r.sd = sd; r.lim = lim;
		r.typed = typed; r.e_found = ef; r.e_ret = er; r.e_lim = el;
		return r;
	endfunction

	function automatic bit [7:0] pick_nbr();
		int s;
		if ($urandom_range(0, 1)) return LIST_END;
		if ($urandom_range(0, 6) == 0) return 8'($urandom_range(128, 254));
		do s = $urandom_range(0, N_SLOTS-1); while (!written[s]);
		return 8'(s);
	endfunction

	function automatic bit [63:0] pick_mask();
		if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
		return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
	endfunction

	task automatic send(row_t r);
		int gap;
		int first;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		req_type = r.req; slot = r.slot;
		mask_low = r.ml; mask_high = r.mh;
		neighbour0 = r.n0; neighbour1 = r.n1; neighbour2 = r.n2; neighbour3 = r.n3;
		visited_in = r.vis; wanted_id = r.id; start_depth = r.sd; initial_limit = r.lim;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		if (r.req == REQ_WRITE) begin
			pm_low[r.slot] = r.ml;
			pm_high[r.slot] = r.mh;
			pm_nbr[r.slot] = '{r.n0, r.n1, r.n2, r.n3};
			pm_vis[r.slot] = r.vis;
			written[r.slot] = 1;
		end else begin
			first = expected_beats.size();
			predict_search(r.slot, r.sd, r.id, r.lim);
			if (r.typed && (expected_beats[first].found != r.e_found ||
					expected_beats[first].return_depth != r.e_ret ||
					expected_beats[first].final_limit != r.e_lim)) begin
				errors++;
				$display("%0t typed search slot %0d: expected found %0d ret %0d lim %0d",
					$time, r.slot, r.e_found, r.e_ret, r.e_lim);
				$display("%0t   predicted found %0d ret %0d lim %0d", $time,
					expected_beats[first].found, expected_beats[first].return_depth,
					expected_beats[first].final_limit);
			end
		end
		@(negedge clk);
	endtask

	// result side: random stalls, calm stretches, one long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (beats_taken == 30) w = 400;
			else if ((beats_taken / 60) % 2 == 1) w = 0;
			else w = $urandom_range(0, 15);
			out_stall = w != 0;
			repeat (w) @(negedge clk);
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			path_beat_t e;
			beats_taken++;
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: slot %0d pos %0d", $time, path_slot, path_pos);
			end else begin
				e = expected_beats.pop_front();
				if (path_slot != e.path_slot || path_pos != e.path_pos || last != e.last ||
						found != e.found || return_depth != e.return_depth ||
						final_limit != e.final_limit || target_slot != e.target_slot) begin
					errors++;
					$display("%0t mismatch expected slot %0d pos %0d last %0d found %0d ret %0d lim %0d tgt %0d",
						$time, e.path_slot, e.path_pos, e.last, e.found, e.return_depth,
						e.final_limit, e.target_slot);
					$display("%0t          actual slot %0d pos %0d last %0d found %0d ret %0d lim %0d tgt %0d",
						$time, path_slot, path_pos, last, found, return_depth,
						final_limit, target_slot);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("bounded_dfs_path_search_tb: done, errors");
			$finish;
		end
	end

	initial begin
		row_t r;
		int s;
		rows.push_back(wr(0, '1, '1, LIST_END, LIST_END, LIST_END, LIST_END, 0));
		rows.push_back(wr(2, 0, 64'h8000_0000_0000_0000, LIST_END, LIST_END, LIST_END,
			LIST_END, 0));
		rows.push_back(wr(1, 0, 0, 200, 2, 0, LIST_END, 1));
		rows.push_back(wr(3, 1, 0, 1, 2, LIST_END, 0, 0));
		rows.push_back(sr(0, 128, 0, 32, 1, 0, 32, 32));
		rows.push_back(sr(1, 0, 0, 0, 1, 0, 0, 0));
		rows.push_back(sr(1, 127, 0, 32, 0, 0, 0, 0));
		rows.push_back(sr(3, 0, 0, 32, 1, 1, 1, 1));
		rows.push_back(sr(0, 5, 31, 32, 1, 1, 32, 32));
		rows.push_back(sr(0, 5, 31, 31, 1, 0, 0, 31));
		rows.push_back(sr(1, 255, 0, 32, 0, 0, 0, 0));
		rows.push_back(wr(3, 0, 64'h1, 1, 255, 0, 2, 0));
		rows.push_back(sr(3, 64, 2, 10, 0, 0, 0, 0));
		rows.push_back(sr(3, 63, 4, 6, 0, 0, 0, 0));
		rows.push_back(sr(1, 127, 0, 1, 0, 0, 0, 0));
		rows.push_back(wr(127, '1, 0, 3, 1, 128, 254, 1));
		rows.push_back(sr(127, 100, 0, 32, 0, 0, 0, 0));
		rows.push_back(sr(127, 0, 30, 32, 0, 0, 0, 0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (rows[i]) send(rows[i]);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i < 40 || $urandom_range(0, 9) < 4) begin
				r = wr(7'($urandom_range(0, N_SLOTS-1)), pick_mask(), pick_mask(),
					pick_nbr(), pick_nbr(), pick_nbr(), pick_nbr(),
					$urandom_range(0, 3) == 0);
			end else begin
				do s = $urandom_range(0, N_SLOTS-1); while (!written[s]);
				r = sr(7'(s), 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) :
					$urandom_range(0, 135)),
					5'($urandom_range(0, 4) == 0 ? $urandom_range(0, 31) :
					$urandom_range(0, 5)),
					6'($urandom_range(0, 4) == 0 ? $urandom_range(0, 32) :
					$urandom_range(0, 14)),
					0, 0, 0, 0);
			end
			send(r);
		end
		in_valid = 0;

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors == 0)
			$display("bounded_dfs_path_search_tb: done, clean");
		else
			$display("bounded_dfs_path_search_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

[bounded_dfs_path_search.f]
+incdir+sv
sv/bdps_pkg.sv
sv/bdps_slot_mem.sv
sv/bounded_dfs_path_search.sv
tb/bounded_dfs_path_search_tb.sv
